// ===== sv/vector3_normalize_macros.svh =====
// Assertion macros for the vector normalizer checker.
`ifndef VECTOR3_NORMALIZE_MACROS_SVH
`define VECTOR3_NORMALIZE_MACROS_SVH

// Clocked assertion, off while reset is held.
`define V3N_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds across reset.
`define V3N_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/v3n_pkg.sv =====
// Shared widths, control struct and side-band types for the vector normalizer.
`timescale 1ns / 1ps
`default_nettype none
package v3n_pkg;

    localparam int CompW     = 32;
    localparam int UnitW     = 18;
    localparam int LenW      = 32;
    localparam int SumW      = 64;
    localparam int QuotW     = 17;
    localparam int RemW      = 34;
    localparam int SqrtSteps = 32;
    localparam int DivSteps  = 17;
    localparam int NumLanes  = 3;
    localparam int InDataW   = 96;
    localparam int OutDataW  = 88;

    typedef struct packed {
        logic en;
        logic valid;
    } t_ctl;

    typedef struct packed {
        logic [NumLanes-1:0][CompW-1:0] mag;
        logic [NumLanes-1:0]            neg;
    } t_side;

endpackage
`default_nettype wire

// ===== sv/v3n_sqrt.sv =====
// Pipelined floor square root, one result bit per stage, with side-band carried along.
`timescale 1ns / 1ps
`default_nettype none
module v3n_sqrt import v3n_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctl             i_ctl,
    input  logic [SumW-1:0]  i_sum,
    input  t_side            i_side,
    output logic             o_valid,
    output logic [LenW-1:0]  o_root,
    output t_side            o_side
);

    logic [SqrtSteps-1:0]            r_valid;
    logic [SqrtSteps-1:0][RemW-1:0]  r_rem;
    logic [SqrtSteps-1:0][LenW-1:0]  r_root;
    logic [SqrtSteps-1:0][SumW-1:0]  r_src;
    t_side [SqrtSteps-1:0]           r_side;

    genvar g;
    generate
        for (g = 0; g < SqrtSteps; g++) begin : g_stage
            logic            w_valid_in;
            logic [RemW-1:0] w_rem_in;
            logic [LenW-1:0] w_root_in;
            logic [SumW-1:0] w_src_in;
            t_side           w_side_in;
            logic [RemW+1:0] w_shift;
            logic [RemW+1:0] w_trial;
            logic [RemW-1:0] n_rem;
            logic [LenW-1:0] n_root;

            if (g == 0) begin : g_first
                assign w_valid_in = i_ctl.valid;
                assign w_rem_in   = '0;
                assign w_root_in  = '0;
                assign w_src_in   = i_sum;
                assign w_side_in  = i_side;
            end else begin : g_next
                assign w_valid_in = r_valid[g-1];
                assign w_rem_in   = r_rem[g-1];
                assign w_root_in  = r_root[g-1];
                assign w_src_in   = r_src[g-1];
                assign w_side_in  = r_side[g-1];
            end

            always_comb begin
                w_shift = {w_rem_in, w_src_in[SumW-1 -: 2]};
                w_trial = {2'b00, w_root_in, 2'b01};
                if (w_shift >= w_trial) begin
                    n_rem  = RemW'(w_shift - w_trial);
                    n_root = {w_root_in[LenW-2:0], 1'b1};
                end else begin
                    n_rem  = w_shift[RemW-1:0];
                    n_root = {w_root_in[LenW-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[g] <= 1'b0;
                end else if (i_ctl.en) begin
                    r_valid[g] <= w_valid_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_ctl.en) begin
                    r_rem[g]  <= n_rem;
                    r_root[g] <= n_root;
                    r_src[g]  <= {w_src_in[SumW-3:0], 2'b00};
                    r_side[g] <= w_side_in;
                end
            end
        end
    endgenerate

    assign o_valid = r_valid[SqrtSteps-1];
    assign o_root  = r_root[SqrtSteps-1];
    assign o_side  = r_side[SqrtSteps-1];

endmodule
`default_nettype wire

// ===== sv/v3n_div_lane.sv =====
// One divider lane: pipelined restoring division of magnitude * 2^16 by the length.
`timescale 1ns / 1ps
`default_nettype none
module v3n_div_lane import v3n_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctl                    i_ctl,
    input  logic [CompW-1:0]        i_mag,
    input  logic                    i_neg,
    input  logic [LenW-1:0]         i_len,
    output logic                    o_valid,
    output logic signed [UnitW-1:0] o_unit,
    output logic [LenW-1:0]         o_len
);

    logic [DivSteps-1:0]             r_valid;
    logic [DivSteps-1:0][LenW-1:0]   r_rem;
    logic [DivSteps-1:0][QuotW-1:0]  r_quot;
    logic [DivSteps-1:0][QuotW-1:0]  r_low;
    logic [DivSteps-1:0][LenW-1:0]   r_den;
    logic [DivSteps-1:0]             r_neg;

    genvar g;
    generate
        for (g = 0; g < DivSteps; g++) begin : g_stage
            logic             w_valid_in;
            logic [LenW-1:0]  w_rem_in;
            logic [QuotW-1:0] w_quot_in;
            logic [QuotW-1:0] w_low_in;
            logic [LenW-1:0]  w_den_in;
            logic             w_neg_in;
            logic [LenW:0]    w_shift;
            logic [LenW-1:0]  n_rem;
            logic             n_bit;

            if (g == 0) begin : g_first
                // quotient stays below 2^17, so the upper dividend bits are below the length
                assign w_valid_in = i_ctl.valid;
                assign w_rem_in   = {1'b0, i_mag[CompW-1:1]};
                assign w_quot_in  = '0;
                assign w_low_in   = {i_mag[0], {(QuotW-1){1'b0}}};
                assign w_den_in   = i_len;
                assign w_neg_in   = i_neg;
            end else begin : g_next
                assign w_valid_in = r_valid[g-1];
                assign w_rem_in   = r_rem[g-1];
                assign w_quot_in  = r_quot[g-1];
                assign w_low_in   = r_low[g-1];
                assign w_den_in   = r_den[g-1];
                assign w_neg_in   = r_neg[g-1];
            end

            always_comb begin
                w_shift = {w_rem_in, w_low_in[QuotW-1]};
                if (w_shift >= {1'b0, w_den_in}) begin
                    n_rem = LenW'(w_shift - {1'b0, w_den_in});
                    n_bit = 1'b1;
                end else begin
                    n_rem = w_shift[LenW-1:0];
                    n_bit = 1'b0;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[g] <= 1'b0;
                end else if (i_ctl.en) begin
                    r_valid[g] <= w_valid_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_ctl.en) begin
                    r_rem[g]  <= n_rem;
                    r_quot[g] <= {w_quot_in[QuotW-2:0], n_bit};
                    r_low[g]  <= {w_low_in[QuotW-2:0], 1'b0};
                    r_den[g]  <= w_den_in;
                    r_neg[g]  <= w_neg_in;
                end
            end
        end
    endgenerate

    always_comb begin
        if (r_neg[DivSteps-1]) begin
            o_unit = -$signed({1'b0, r_quot[DivSteps-1]});
        end else begin
            o_unit = $signed({1'b0, r_quot[DivSteps-1]});
        end
    end

    assign o_valid = r_valid[DivSteps-1];
    assign o_len   = r_den[DivSteps-1];

endmodule
`default_nettype wire

// ===== sv/vector3_normalize.sv =====
// Top level: 3D vector normalizer, Q16.16 in, Q1.16 unit vector and length out.
// Usage:
//   Input word on the s_axis channel: x, y, z components, signed Q16.16.
//   Output word on the m_axis channel: unit x/y/z in signed Q1.16 (truncated
//   toward zero), the length in unsigned Q16.16, and a zero flag in tuser.
//   A zero vector gives zero unit components, zero length and the flag set.
// Throughput: one word per cycle, sustained, when the receiver keeps up.
// Pipeline from input accept to output valid: magnitude, square
//   (32x32 multiply) and sum registers, 32 square root stages (one root bit
//   each), 17 divider stages in three parallel lanes (one quotient bit each),
//   and the output register.
// Reset: synchronous, active low; clears all valid flags, payload is not reset.
// Stall: a held output word freezes in place; one more finished word goes to a
//   skid register, after which the whole pipeline holds and s_axis tready
//   drops until the output is taken.
`timescale 1ns / 1ps
`default_nettype none
module vector3_normalize import v3n_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // comp_x [31:0], comp_y [63:32], comp_z [95:64]
    input  logic [InDataW-1:0]  i_s_axis_tdata,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // unit_x [17:0], unit_y [35:18], unit_z [53:36], vec_length [85:54], zero pad [87:86]
    output logic [OutDataW-1:0] o_m_axis_tdata,
    // zero_length [0]
    output logic                o_m_axis_tuser
);

    logic w_en;
    t_ctl w_sqrt_ctl;
    t_ctl w_div_ctl;

    logic                           r_a_valid;
    logic [NumLanes-1:0][CompW-1:0] r_a_mag;
    logic [NumLanes-1:0]            r_a_neg;
    logic                           r_b_valid;
    logic [NumLanes-1:0][SumW-1:0]  r_b_sq;
    logic [NumLanes-1:0][CompW-1:0] r_b_mag;
    logic [NumLanes-1:0]            r_b_neg;
    logic                           r_c_valid;
    logic [SumW-1:0]                r_c_sum;
    t_side                          r_c_side;

    logic [NumLanes-1:0][CompW-1:0] n_a_mag;
    logic [NumLanes-1:0]            n_a_neg;

    logic                           w_sq_valid;
    logic [LenW-1:0]                w_root;
    t_side                          w_sq_side;

    logic [NumLanes-1:0]                   w_lane_valid;
    logic signed [NumLanes-1:0][UnitW-1:0] w_lane_unit;
    logic [NumLanes-1:0][LenW-1:0]         w_lane_len;

    logic                r_out_valid;
    logic                r_skid_valid;
    logic [OutDataW-1:0] r_out_data;
    logic                r_out_zero;
    logic [OutDataW-1:0] r_skid_data;
    logic                r_skid_zero;
    logic                n_out_valid;
    logic                n_skid_valid;
    logic [OutDataW-1:0] n_out_data;
    logic                n_out_zero;
    logic [OutDataW-1:0] n_skid_data;
    logic                n_skid_zero;

    logic                w_res_valid;
    logic                w_res_zero;
    logic [OutDataW-1:0] w_res_data;
    logic                w_take;

    // pipeline moves unless the skid register is occupied
    assign w_en            = !r_skid_valid;
    assign o_s_axis_tready = w_en;

    always_comb begin
        for (int i = 0; i < NumLanes; i++) begin
            n_a_neg[i] = i_s_axis_tdata[i*CompW + CompW - 1];
            // most negative value wraps to 2^31, exact as unsigned
            n_a_mag[i] = n_a_neg[i] ? (~i_s_axis_tdata[i*CompW +: CompW] + CompW'(1))
                                    : i_s_axis_tdata[i*CompW +: CompW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_s_axis_tvalid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_mag <= n_a_mag;
            r_a_neg <= n_a_neg;
            for (int i = 0; i < NumLanes; i++) begin
                r_b_sq[i] <= SumW'(r_a_mag[i]) * SumW'(r_a_mag[i]);
            end
            r_b_mag       <= r_a_mag;
            r_b_neg       <= r_a_neg;
            r_c_sum       <= r_b_sq[0] + r_b_sq[1] + r_b_sq[2];
            r_c_side.mag  <= r_b_mag;
            r_c_side.neg  <= r_b_neg;
        end
    end

    assign w_sqrt_ctl.en    = w_en;
    assign w_sqrt_ctl.valid = r_c_valid;

    v3n_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_sqrt_ctl),
        .i_sum   (r_c_sum),
        .i_side  (r_c_side),
        .o_valid (w_sq_valid),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    assign w_div_ctl.en    = w_en;
    assign w_div_ctl.valid = w_sq_valid;

    genvar l;
    generate
        for (l = 0; l < NumLanes; l++) begin : g_lane
            v3n_div_lane u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_div_ctl),
                .i_mag   (w_sq_side.mag[l]),
                .i_neg   (w_sq_side.neg[l]),
                .i_len   (w_root),
                .o_valid (w_lane_valid[l]),
                .o_unit  (w_lane_unit[l]),
                .o_len   (w_lane_len[l])
            );
        end
    endgenerate

    // merge the lanes; a zero length overrides whatever the dividers produced
    always_comb begin
        w_res_valid = w_en && (&w_lane_valid);
        w_res_zero  = (w_lane_len[0] == '0);
        if (w_res_zero) begin
            w_res_data = '0;
        end else begin
            w_res_data = {2'b00, w_lane_len[0], w_lane_unit[2], w_lane_unit[1],
                          w_lane_unit[0]};
        end
    end

    assign w_take = r_out_valid && i_m_axis_tready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out_data   = r_out_data;
        n_out_zero   = r_out_zero;
        n_skid_data  = r_skid_data;
        n_skid_zero  = r_skid_zero;
        if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_out_zero   = r_skid_zero;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = w_res_valid;
                n_out_data  = w_res_data;
                n_out_zero  = w_res_zero;
            end
        end else if (w_res_valid) begin
            n_skid_valid = 1'b1;
            n_skid_data  = w_res_data;
            n_skid_zero  = w_res_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_out_zero  <= n_out_zero;
        r_skid_data <= n_skid_data;
        r_skid_zero <= n_skid_zero;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_zero;

endmodule
`default_nettype wire

// ===== sv/v3n_checker.sv =====
// Port-level checker for the vector normalizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "vector3_normalize_macros.svh"
module v3n_checker import v3n_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_axis_tvalid,
    input logic                o_s_axis_tready,
    input logic [InDataW-1:0]  i_s_axis_tdata,
    input logic                o_m_axis_tvalid,
    input logic                i_m_axis_tready,
    input logic [OutDataW-1:0] o_m_axis_tdata,
    input logic                o_m_axis_tuser
);

    // zero flag means every output field is zero
    `V3N_ASSERT_RST(a_zero_clears, o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0, "zero flag with nonzero data")

    // a nonzero vector has a nonzero length
    `V3N_ASSERT_RST(a_len_nonzero, o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata[85:54] != '0, "length zero without flag")

    // unit x stays within plus or minus one
    `V3N_ASSERT_RST(a_unit_range, o_m_axis_tvalid |-> ($signed(o_m_axis_tdata[17:0]) <= 18'sd65536) && ($signed(o_m_axis_tdata[17:0]) >= -18'sd65536), "unit x out of range")

    // a stalled word holds
    `V3N_ASSERT_RST(a_stall_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "output changed while stalled")

    // nothing comes out right after reset
    `V3N_ASSERT(a_reset_idle, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")

endmodule

bind vector3_normalize v3n_checker u_v3n_checker (.*);
`default_nettype wire

// ===== dv/vector3_normalize_test.sv =====
// Testbench for the 3D vector normalizer: random and directed vectors checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module vector3_normalize_test;
    import v3n_pkg::*;

    typedef struct packed {
        logic [UnitW-1:0] ux;
        logic [UnitW-1:0] uy;
        logic [UnitW-1:0] uz;
        logic [LenW-1:0]  len;
        logic             zero;
    } t_norm;

    // floor square root of a 64-bit sum, one root bit per step
    function automatic logic [LenW-1:0] isqrt64(logic [SumW-1:0] s);
        logic [SumW-1:0] res;
        logic [SumW-1:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s   = s - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[LenW-1:0];
    endfunction

    function automatic logic [UnitW-1:0] unit_of(logic [CompW-1:0] c, logic [LenW-1:0] len);
        logic [SumW-1:0] mag;
        logic [SumW-1:0] q;
        mag = c[CompW-1] ? (64'h1_0000_0000 - {32'd0, c}) : {32'd0, c};
        q   = (mag << 16) / {32'd0, len};
        return c[CompW-1] ? (UnitW'(0) - q[UnitW-1:0]) : q[UnitW-1:0];
    endfunction

    function automatic t_norm normalize(logic [InDataW-1:0] d);
        logic [SumW-1:0] s;
        logic [SumW-1:0] m;
        t_norm r;
        s = '0;
        for (int k = 0; k < NumLanes; k++) begin
            m = d[k*CompW+CompW-1] ? (64'h1_0000_0000 - {32'd0, d[k*CompW +: CompW]})
                                  : {32'd0, d[k*CompW +: CompW]};
            s = s + m * m;
        end
        r.len = isqrt64(s);
        if (r.len == 0) begin
            r = '0;
            r.zero = 1'b1;
        end else begin
            r.ux = unit_of(d[31:0], r.len);
            r.uy = unit_of(d[63:32], r.len);
            r.uz = unit_of(d[95:64], r.len);
            r.zero = 1'b0;
        end
        return r;
    endfunction

    class norm_board;
        t_norm pending[$];
        int    errors;
        int    checked;

        function void note_input(logic [InDataW-1:0] d);
            pending.push_back(normalize(d));
        endfunction

        function void check_word(logic [OutDataW-1:0] d, logic u);
            t_norm e;
            t_norm a;
            a.ux = d[17:0]; a.uy = d[35:18]; a.uz = d[53:36];
            a.len = d[85:54]; a.zero = u;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected output word %h user %b", d, u);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (a !== e || d[87:86] !== 2'b00) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp ux %h uy %h uz %h len %h z %b,",
                              " got ux %h uy %h uz %h len %h z %b"},
                             e.ux, e.uy, e.uz, e.len, e.zero,
                             a.ux, a.uy, a.uz, a.len, a.zero);
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_axis_tvalid;
    logic                o_s_axis_tready;
    logic [InDataW-1:0]  i_s_axis_tdata;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready;
    logic [OutDataW-1:0] o_m_axis_tdata;
    logic                o_m_axis_tuser;

    vector3_normalize u_dut (.*);

    norm_board board;
    int  cycles;
    bit  hold_sink;
    int  sent;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("timeout after %0d cycles", cycles);
            $display("[vector3_normalize] ERROR");
            $finish;
        end
    end

    function automatic logic [CompW-1:0] pick_comp();
        unique case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return $urandom_range(0, 8) - 4;
            4: return 32'($signed($urandom_range(0, 131072)) - 65536);
            default: return $urandom;
        endcase
    endfunction

    // offer one word after a random gap if gaps is set, hold until accepted
    task automatic send_word(logic [InDataW-1:0] d, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 4) : 0;
        repeat (gap) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        board.note_input(d);
        sent++;
        @(negedge i_clk);
    endtask

    // receiver: random wait before each word, plus one long hold-off
    initial begin
        int w;
        i_m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            w = $urandom_range(0, 4);
            while (w > 0 || hold_sink) begin
                i_m_axis_tready <= 1'b0;
                if (!hold_sink) w--;
                @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_word(o_m_axis_tdata, o_m_axis_tuser);

    initial begin
        logic [CompW-1:0] dx [16];
        board = new();
        hold_sink = 1'b0;
        sent = 0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        dx = '{32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h1, 32'hffff_ffff, 32'h0001_0000,
               32'hffff_0000, 32'h8000_0001, 32'h0000_ffff, 32'h5555_5555, 32'haaaa_aaaa,
               32'h0000_0003, 32'h0000_0004, 32'h4000_0000, 32'hc000_0000, 32'h0};
        // directed: zero vector, extremes, single-axis and mixed signs
        send_word('0, 1'b1);
        send_word({3{32'h8000_0000}}, 1'b1);
        send_word({3{32'h7fff_ffff}}, 1'b1);
        send_word({32'h0, 32'h0, 32'h8000_0000}, 1'b1);
        send_word({32'h0, 32'h7fff_ffff, 32'h0}, 1'b1);
        send_word({32'h1, 32'h0, 32'h0}, 1'b1);
        send_word({32'hffff_ffff, 32'h0, 32'h0}, 1'b1);
        for (int k = 0; k < 16; k++)
            send_word({dx[k], dx[(k+5)%16], dx[(k+11)%16]}, 1'b1);
        // long receiver hold-off while words keep coming: pipeline fills, input stalls
        fork
            begin
                hold_sink = 1'b1;
                repeat (200) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            for (int k = 0; k < 120; k++)
                send_word({pick_comp(), pick_comp(), pick_comp()}, 1'b0);
        join
        for (int k = 0; k < 1100; k++) begin
            send_word({pick_comp(), pick_comp(), pick_comp()}, 1'b1);
            if (k == 600) begin
                // sender pauses until the pipeline has drained
                i_s_axis_tvalid <= 1'b0;
                while (board.pending.size() != 0) @(negedge i_clk);
            end
        end
        i_s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
        $display("sent %0d vectors (zero, extreme, small and random), checked %0d results",
                 sent, board.checked);
        $display("included a long output stall and a full drain pause, %0d errors", board.errors);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("[vector3_normalize] OK");
        end else begin
            $display("[vector3_normalize] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
